// File: rtl/bpa_pkg.sv
// Shared constants and types for the buddy page allocator.
package bpa_pkg;

  localparam int POOL_PAGES = 1024;
  localparam int LEVELS     = $clog2(POOL_PAGES);
  localparam int NODES      = 2 * POOL_PAGES - 1;
  localparam int NODE_W     = $clog2(NODES);
  localparam int SIZE_W     = LEVELS + 1;

  localparam int WANT_W     = 11;
  localparam int PAGE_W     = 10;
  localparam int BLK_W      = 11;
  localparam int NEED_W     = WANT_W + 1;
  localparam int CMP_W      = (NEED_W > SIZE_W) ? NEED_W : SIZE_W;

  localparam int IN_DW      = ((WANT_W + PAGE_W + 7) / 8) * 8;
  localparam int OUT_DW     = ((PAGE_W + BLK_W + 7) / 8) * 8;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_AROOT,
    ST_ALEFT,
    ST_ARIGHT,
    ST_CLIMB,
    ST_FUP,
    ST_DONE
  } state_e;

endpackage

// File: rtl/buddy_page_allocator.sv
// Binary buddy page allocator built around one free-size tree memory.
//
//   channel  dir  fields (tdata low bit up)             tuser
//   s_axis   in   pages_wanted[10:0], page_index[20:11] op (0 alloc, 1 free)
//   m_axis   out  first_page[9:0], block_pages[20:10]   ok
//
// One request at a time; the single read port of the tree memory sets the pace.
// Alloc: the root is checked (a request it cannot fit is refused), then the walk goes down a level
// at a time, probing the left child and then the right, and climbs back to the root; a node whose
// children both fail is granted whole. Free: up from the leaf to the granted node, then up to the root.
// After reset a clearing pass writes all 2047 nodes, one per cycle; no word is taken then.
// A finished result waits in the output register; the next word is taken meanwhile.
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // pages_wanted, page_index, zero pad
  input  logic              s_axis_tuser,   // op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // first_page, block_pages, zero pad
  output logic              m_axis_tuser    // ok
);

  state_e state_q, state_d;

  logic [SIZE_W-1:0] tree_mem [NODES];
  logic [SIZE_W-1:0] rd_q;
  logic              mem_we;
  logic [NODE_W-1:0] mem_wa, mem_ra;
  logic [SIZE_W-1:0] mem_wd;

  logic [NODE_W-1:0] node_q, node_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] lvl_end_q, lvl_end_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [PAGE_W-1:0] first_q, first_d;
  logic [SIZE_W-1:0] blk_q, blk_d;
  logic              ok_q, ok_d;
  logic              op_q, op_d;

  logic              m_valid_q;
  logic [PAGE_W-1:0] m_first_q;
  logic [BLK_W-1:0]  m_blk_q;
  logic              m_ok_q;

  logic              in_acc, out_free;
  logic [WANT_W-1:0] want, want_m1;
  logic [NEED_W-1:0] need_new;
  logic [PAGE_W-1:0] page;
  logic              page_bad;
  logic [NODE_W-1:0] leaf, left_n, right_n, parent_n, sib_n, sib_par;
  logic [SIZE_W-1:0] size_half, size_dbl, merge_val;
  logic              fits, half_leaf;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign want     = s_axis_tdata[WANT_W-1:0];
  assign page     = s_axis_tdata[WANT_W+PAGE_W-1:WANT_W];
  assign page_bad = 32'(page) >= POOL_PAGES;
  assign leaf     = NODE_W'(page) + NODE_W'(POOL_PAGES - 1);

  // round up to a power of two: smear the bits of want-1, then add one
  always_comb begin
    want_m1 = (want == '0) ? '0 : want - WANT_W'(1);
    for (int s = 1; s < WANT_W; s = s * 2) begin
      want_m1 = want_m1 | (want_m1 >> s);
    end
    need_new = NEED_W'(want_m1) + NEED_W'(1);
  end

  assign left_n    = {node_q[NODE_W-2:0], 1'b1};
  assign right_n   = left_n + NODE_W'(1);
  assign parent_n  = (node_q - NODE_W'(1)) >> 1;
  assign sib_n     = node_q[0] ? node_q + NODE_W'(1) : node_q - NODE_W'(1);
  assign sib_par   = parent_n[0] ? parent_n + NODE_W'(1) : parent_n - NODE_W'(1);
  assign size_half = size_q >> 1;
  assign size_dbl  = size_q << 1;
  assign half_leaf = size_half == SIZE_W'(1);
  assign fits      = CMP_W'(rd_q) >= CMP_W'(need_q);
  assign merge_val = (cur_q == size_q && rd_q == size_q) ? size_dbl :
                     ((cur_q > rd_q) ? cur_q : rd_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (node_q == NODE_W'(NODES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_ALLOC) state_d = ST_AROOT;
          else if (page_bad)            state_d = ST_DONE;
          else                          state_d = ST_FUP;
        end
      end
      ST_AROOT: begin
        state_d = fits ? ST_ALEFT : ST_DONE;
      end
      ST_ALEFT: begin
        if (fits) state_d = half_leaf ? ST_CLIMB : ST_ALEFT;
        else      state_d = ST_ARIGHT;
      end
      ST_ARIGHT: begin
        if (fits)                 state_d = half_leaf ? ST_CLIMB : ST_ALEFT;
        else if (node_q == '0)    state_d = ST_DONE;
        else                      state_d = ST_CLIMB;
      end
      ST_CLIMB: begin
        if (parent_n == '0) state_d = ST_DONE;
      end
      ST_FUP: begin
        if (rd_q == '0)        state_d = (node_q == '0) ? ST_DONE : ST_CLIMB;
        else if (node_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // datapath and memory port control
  always_comb begin
    node_d    = node_q;
    size_d    = size_q;
    cur_d     = cur_q;
    lvl_end_d = lvl_end_q;
    need_d    = need_q;
    first_d   = first_q;
    blk_d     = blk_q;
    ok_d      = ok_q;
    op_d      = op_q;
    mem_we    = 1'b0;
    mem_wa    = node_q;
    mem_wd    = size_q;
    mem_ra    = node_q;
    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (node_q != NODE_W'(NODES - 1)) begin
          node_d = node_q + NODE_W'(1);
          if (node_q == lvl_end_q) begin
            size_d    = size_half;
            lvl_end_d = NODE_W'({lvl_end_q, 1'b0} + NODE_W'(2));
          end
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d = s_axis_tuser;
          if (s_axis_tuser == OP_ALLOC) begin
            need_d  = need_new;
            node_d  = '0;
            size_d  = SIZE_W'(POOL_PAGES);
            first_d = '0;
            mem_ra  = '0;
          end else begin
            first_d = page;
            ok_d    = 1'b0;
            blk_d   = '0;
            node_d  = leaf;
            size_d  = SIZE_W'(1);
            mem_ra  = leaf;
          end
        end
      end
      ST_AROOT: begin
        if (fits) begin
          mem_ra = left_n;
        end else begin
          ok_d    = 1'b0;
          first_d = '0;
          blk_d   = '0;
        end
      end
      ST_ALEFT, ST_ARIGHT: begin
        if (fits) begin
          // descend into the child that fits
          node_d = (state_q == ST_ALEFT) ? left_n : right_n;
          size_d = size_half;
          if (state_q == ST_ARIGHT) first_d = first_q + PAGE_W'(size_half);
          if (half_leaf) begin
            mem_we = 1'b1;
            mem_wa = node_d;
            mem_wd = '0;
            mem_ra = node_d[0] ? node_d + NODE_W'(1) : node_d - NODE_W'(1);
            cur_d  = '0;
            blk_d  = size_half;
            ok_d   = 1'b1;
          end else begin
            mem_ra = {node_d[NODE_W-2:0], 1'b1};
          end
        end else if (state_q == ST_ALEFT) begin
          mem_ra = right_n;
        end else begin
          // neither child fits: grant this node whole
          mem_we = 1'b1;
          mem_wa = node_q;
          mem_wd = '0;
          mem_ra = sib_n;
          cur_d  = '0;
          blk_d  = size_q;
          ok_d   = 1'b1;
        end
      end
      ST_CLIMB: begin
        mem_we = 1'b1;
        mem_wa = parent_n;
        mem_wd = merge_val;
        mem_ra = sib_par;
        cur_d  = merge_val;
        node_d = parent_n;
        size_d = size_dbl;
      end
      ST_FUP: begin
        if (rd_q == '0) begin
          mem_we = 1'b1;
          mem_wa = node_q;
          mem_wd = size_q;
          mem_ra = sib_n;
          cur_d  = size_q;
          blk_d  = size_q;
          ok_d   = 1'b1;
        end else if (node_q != '0) begin
          node_d = parent_n;
          size_d = size_dbl;
          mem_ra = parent_n;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tree_mem[mem_wa] <= mem_wd;
    rd_q <= tree_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      node_q    <= '0;
      size_q    <= SIZE_W'(POOL_PAGES);
      lvl_end_q <= '0;
      cur_q     <= '0;
      need_q    <= '0;
      first_q   <= '0;
      blk_q     <= '0;
      ok_q      <= 1'b0;
      op_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      node_q    <= node_d;
      size_q    <= size_d;
      lvl_end_q <= lvl_end_d;
      cur_q     <= cur_d;
      need_q    <= need_d;
      first_q   <= first_d;
      blk_q     <= blk_d;
      ok_q      <= ok_d;
      op_q      <= op_d;
      if (state_q == ST_DONE && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready)             m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      m_first_q <= first_q;
      m_blk_q   <= BLK_W'(blk_q);
      m_ok_q    <= ok_q;
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_ok_q;
  assign m_axis_tdata  = {{(OUT_DW - PAGE_W - BLK_W){1'b0}}, m_blk_q, m_first_q};

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_we)
    else $error("tree written while idle");

  a_size_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALEFT || state_q == ST_ARIGHT || state_q == ST_CLIMB ||
     state_q == ST_FUP) |-> $onehot(size_q))
    else $error("block size is not a power of two");

  a_grant_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && ok_q && op_q == OP_ALLOC) |->
      CMP_W'(blk_q) >= CMP_W'(need_q))
    else $error("granted block smaller than request");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second word taken while busy");
`endif

endmodule
